// File: design/hba_pkg.sv
// shared types and constants of the heap block allocator
// no dependencies; imported by every module of the block

package hba_pkg;

    // default geometry of the heap region
    localparam int HEAP_BYTES_DEF   = 65536;
    localparam int HEADER_BYTES_DEF = 12;
    localparam int HEAP_BYTES_MAX   = 32'h200_0000;

    // width of one header word: size in bytes, bit 0 marks a used block
    localparam int HDR_W = 17;

    // sizes are kept as multiples of four bytes
    localparam int ALIGN_MASK = 3;

    // field widths of the channels
    localparam int CMD_W   = 2;
    localparam int FIELD_W = 16;
    localparam int TOTAL_W = 17;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_COMPACT = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

endpackage

// File: design/hba_hdr_mem.sv
// header memory: one synchronous write port, one registered read port
// depends on hba_pkg for the header word width

module hba_hdr_mem
    import hba_pkg::*;
#(
    parameter int DEPTH = HEAP_BYTES_DEF / 4
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [HDR_W-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [HDR_W-1:0]         i_wr_data
);

    logic [HDR_W-1:0] r_mem [DEPTH];
    logic [HDR_W-1:0] r_rd_data;

    // write, and read with the new word forwarded on an address match
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/hba_engine.sv
// command sequencer: fast path, header walk with merging, free, result register
// depends on hba_pkg; drives the ports of hba_hdr_mem

module hba_engine
    import hba_pkg::*;
#(
    parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [CMD_W-1:0]                     i_cmd,
    input  logic [FIELD_W-1:0]                   i_request_size,
    input  logic [FIELD_W-1:0]                   i_user_address,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [FIELD_W-1:0]                   o_result_address,
    output logic                                 o_success,
    output logic [TOTAL_W-1:0]                   o_allocated_bytes,
    output logic [TOTAL_W-1:0]                   o_available_bytes,
    output logic                                 o_mem_rd_en,
    output logic [$clog2(HEAP_BYTES/4)-1:0]      o_mem_rd_addr,
    input  logic [HDR_W-1:0]                     i_mem_rd_data,
    output logic                                 o_mem_wr_en,
    output logic [$clog2(HEAP_BYTES/4)-1:0]      o_mem_wr_addr,
    output logic [HDR_W-1:0]                     o_mem_wr_data
);

    localparam int HDR_WORDS = HEAP_BYTES / 4;
    localparam int AW        = $clog2(HDR_WORDS);
    localparam int LOG_HEAP  = $clog2(HEAP_BYTES);
    // offsets may run one block past the end of the heap
    localparam int OFF_W     = ((LOG_HEAP > HDR_W) ? LOG_HEAP : HDR_W) + 1;
    localparam int CW        = $clog2(HDR_WORDS + 1);

    localparam logic [OFF_W-1:0] HEAP_V  = OFF_W'(HEAP_BYTES);
    localparam logic [OFF_W-1:0] HDR_V   = OFF_W'(HEADER_BYTES);
    localparam logic [OFF_W-1:0] END_V   = OFF_W'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [OFF_W-1:0] ROUND_V = OFF_W'(HEADER_BYTES + ALIGN_MASK);
    localparam logic [OFF_W-1:0] MASK_V  = ~OFF_W'(ALIGN_MASK);
    localparam logic [AW-1:0]    END_IDX = AW'((HEAP_BYTES - HEADER_BYTES) / 4);
    localparam logic [CW-1:0]    WALK_MAX = CW'(HDR_WORDS);

    typedef enum logic [3:0] {
        ST_INIT0,
        ST_INIT1,
        ST_IDLE,
        ST_DISPATCH,
        ST_AFP,
        ST_WALK,
        ST_WEND,
        ST_TAKE,
        ST_MARK,
        ST_FREE,
        ST_FINISH
    } t_state;

    t_state               r_state, n_state;
    t_cmd                 r_cmd;
    logic [FIELD_W-1:0]   r_req, r_ua;
    logic [OFF_W-1:0]     r_need, n_need;
    logic [OFF_W-1:0]     r_p, n_p;
    logic [OFF_W-1:0]     r_best, n_best;
    logic [OFF_W-1:0]     r_run, n_run;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [HDR_W-1:0]     r_fsize, n_fsize;
    logic [OFF_W-1:0]     r_free_off, n_free_off;
    logic                 r_free_valid, n_free_valid;
    logic [TOTAL_W-1:0]   r_total, n_total;
    logic [FIELD_W-1:0]   r_addr, n_addr;
    logic                 r_ok, n_ok;
    logic                 r_out_valid, n_out_valid;
    logic                 w_load;
    logic [FIELD_W-1:0]   r_out_addr;
    logic                 r_out_ok;
    logic [TOTAL_W-1:0]   r_out_alloc, r_out_avail;
    logic [TOTAL_W-1:0]   w_avail;

    // header word index of a byte offset
    function automatic logic [AW-1:0] idx(input logic [OFF_W-1:0] off);
        return off[AW+1:2];
    endfunction

    assign o_in_ready = (r_state == ST_IDLE);

    // bytes left for the result transaction
    always_comb begin
        if (OFF_W'(r_total) < HEAP_V) begin
            w_avail = TOTAL_W'(HEAP_V - OFF_W'(r_total));
        end else begin
            w_avail = '0;
        end
    end

    // next state, read-modify-write traffic to the header memory
    always_comb begin
        logic [HDR_W-1:0] s;
        logic [OFF_W-1:0] s_sz;
        logic [OFF_W-1:0] p_nxt;
        logic [OFF_W-1:0] off;
        logic [CW-1:0]    cnt_nxt;
        logic             have;

        s       = i_mem_rd_data;
        s_sz    = OFF_W'(s) & MASK_V;
        p_nxt   = r_p + s_sz;
        cnt_nxt = r_cnt + CW'(1);
        off     = OFF_W'(r_ua) - HDR_V;
        have    = (r_run != '0) && (r_run >= r_need);

        n_state      = r_state;
        n_need       = r_need;
        n_p          = r_p;
        n_best       = r_best;
        n_run        = r_run;
        n_cnt        = r_cnt;
        n_fsize      = r_fsize;
        n_free_off   = r_free_off;
        n_free_valid = r_free_valid;
        n_total      = r_total;
        n_addr       = r_addr;
        n_ok         = r_ok;
        w_load       = 1'b0;

        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = '0;
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = '0;
        o_mem_wr_data = '0;

        unique case (r_state)
            // lay down the first and the end header after reset
            ST_INIT0: begin
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = '0;
                o_mem_wr_data = HDR_W'(END_V);
                n_state       = ST_INIT1;
            end
            ST_INIT1: begin
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = END_IDX;
                o_mem_wr_data = '0;
                n_state       = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_addr  = '0;
                n_ok    = 1'b0;
                n_state = ST_FINISH;
                unique case (r_cmd)
                    CMD_ALLOC: begin
                        n_need = (OFF_W'(r_req) + ROUND_V) & MASK_V;
                        if (r_req != '0) begin
                            if (r_free_valid && (r_free_off < HEAP_V)) begin
                                o_mem_rd_en   = 1'b1;
                                o_mem_rd_addr = idx(r_free_off);
                                n_state       = ST_AFP;
                            end else begin
                                n_p           = '0;
                                n_best        = '0;
                                n_run         = '0;
                                n_cnt         = '0;
                                o_mem_rd_en   = 1'b1;
                                o_mem_rd_addr = '0;
                                n_state       = ST_WALK;
                            end
                        end
                    end
                    CMD_FREE: begin
                        if (r_ua == '0) begin
                            n_ok = 1'b1;
                        end else if ((OFF_W'(r_ua) >= HDR_V) && (off[1:0] == 2'b00)
                                     && (off < END_V)) begin
                            n_p           = off;
                            o_mem_rd_en   = 1'b1;
                            o_mem_rd_addr = idx(off);
                            n_state       = ST_FREE;
                        end
                    end
                    CMD_COMPACT: begin
                        n_need        = HEAP_V;
                        n_p           = '0;
                        n_best        = '0;
                        n_run         = '0;
                        n_cnt         = '0;
                        o_mem_rd_en   = 1'b1;
                        o_mem_rd_addr = '0;
                        n_state       = ST_WALK;
                    end
                    CMD_NOP: begin
                        n_state = ST_FINISH;
                    end
                endcase
            end
            // block at the free pointer: take it or fall back to the walk
            ST_AFP: begin
                if (r_need > OFF_W'(s)) begin
                    n_p           = '0;
                    n_best        = '0;
                    n_run         = '0;
                    n_cnt         = '0;
                    o_mem_rd_en   = 1'b1;
                    o_mem_rd_addr = '0;
                    n_state       = ST_WALK;
                end else begin
                    n_p     = r_free_off;
                    n_fsize = s;
                    n_state = ST_TAKE;
                end
            end
            // one header per cycle, merging free runs into their first header
            ST_WALK: begin
                if (s == '0) begin
                    n_state = ST_WEND;
                end else if (s[0] && have) begin
                    n_state = ST_WEND;
                end else begin
                    if (s[0]) begin
                        if ((r_run != '0) && (r_best < HEAP_V)) begin
                            o_mem_wr_en   = 1'b1;
                            o_mem_wr_addr = idx(r_best);
                            o_mem_wr_data = r_run[HDR_W-1:0];
                        end
                        n_run  = '0;
                        n_best = p_nxt;
                    end else begin
                        n_run = r_run + s_sz;
                    end
                    n_p   = p_nxt;
                    n_cnt = cnt_nxt;
                    if ((p_nxt >= HEAP_V) || (cnt_nxt == WALK_MAX)) begin
                        n_state = ST_WEND;
                    end else begin
                        o_mem_rd_en   = 1'b1;
                        o_mem_rd_addr = idx(p_nxt);
                    end
                end
            end
            // close the last run and settle the free pointer
            ST_WEND: begin
                if ((r_run != '0) && (r_best < HEAP_V)) begin
                    o_mem_wr_en   = 1'b1;
                    o_mem_wr_addr = idx(r_best);
                    o_mem_wr_data = r_run[HDR_W-1:0];
                end
                n_free_valid = have;
                n_free_off   = have ? r_best : '0;
                if (r_cmd == CMD_COMPACT) begin
                    n_ok    = 1'b1;
                    n_state = ST_FINISH;
                end else if (have) begin
                    n_p     = r_best;
                    n_fsize = r_run[HDR_W-1:0];
                    n_state = ST_TAKE;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            // split off the remainder when it can hold a header
            ST_TAKE: begin
                if (OFF_W'(r_fsize) >= (r_need + HDR_V)) begin
                    n_free_off = r_p + r_need;
                    if ((r_p + r_need) < HEAP_V) begin
                        o_mem_wr_en   = 1'b1;
                        o_mem_wr_addr = idx(r_p + r_need);
                        o_mem_wr_data = HDR_W'(OFF_W'(r_fsize) - r_need);
                    end
                end else begin
                    n_free_valid = 1'b0;
                    n_free_off   = '0;
                    n_need       = OFF_W'(r_fsize);
                end
                n_state = ST_MARK;
            end
            // mark the block used and book its size
            ST_MARK: begin
                n_total = TOTAL_W'(OFF_W'(r_total) + r_need);
                if (r_p < HEAP_V) begin
                    o_mem_wr_en   = 1'b1;
                    o_mem_wr_addr = idx(r_p);
                    o_mem_wr_data = HDR_W'(r_need) | HDR_W'(1);
                end
                n_addr  = FIELD_W'(r_p + HDR_V);
                n_ok    = 1'b1;
                n_state = ST_FINISH;
            end
            // release a used block, total saturates at zero
            ST_FREE: begin
                if (s[0]) begin
                    o_mem_wr_en   = 1'b1;
                    o_mem_wr_addr = idx(r_p);
                    o_mem_wr_data = {s[HDR_W-1:1], 1'b0};
                    if (r_total > {s[HDR_W-1:1], 1'b0}) begin
                        n_total = r_total - {s[HDR_W-1:1], 1'b0};
                    end else begin
                        n_total = '0;
                    end
                    n_ok = 1'b1;
                end
                n_state = ST_FINISH;
            end
            // hand the result to the output register once it is free
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // state, captured command and result register
    always_ff @(posedge i_clk) begin
        r_need  <= n_need;
        r_p     <= n_p;
        r_best  <= n_best;
        r_run   <= n_run;
        r_cnt   <= n_cnt;
        r_fsize <= n_fsize;
        r_addr  <= n_addr;
        r_ok    <= n_ok;
        if ((r_state == ST_IDLE) && i_in_valid) begin
            r_cmd <= t_cmd'(i_cmd);
            r_req <= i_request_size;
            r_ua  <= i_user_address;
        end
        if (w_load) begin
            r_out_addr  <= r_addr;
            r_out_ok    <= r_ok;
            r_out_alloc <= r_total;
            r_out_avail <= w_avail;
        end
        if (!i_rst_n) begin
            r_state      <= ST_INIT0;
            r_free_off   <= '0;
            r_free_valid <= 1'b1;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_off   <= n_free_off;
            r_free_valid <= n_free_valid;
            r_total      <= n_total;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_address  = r_out_addr;
    assign o_success         = r_out_ok;
    assign o_allocated_bytes = r_out_alloc;
    assign o_available_bytes = r_out_avail;

endmodule

// File: design/heap_block_allocator_core.sv
// Heap block allocator. Commands enter on the input channel (i_in_valid,
// o_in_ready) with fields i_cmd, i_request_size and i_user_address; each
// command gives one result transaction on the output channel (o_out_valid,
// i_out_ready): address, success flag, allocated and available bytes.
// One command is worked on at a time; the header memory has one read and
// one write port with a registered read port, and sets the timing.
// Paths from acceptance to a valid result: a null or malformed free, a zero
// request and a no-op go straight to the result; a free of a well-formed
// address reads its header first; an allocate tries the block at a valid
// free pointer, else walks the headers, one a cycle, then splits and marks
// the block it found; compact and a failed walk end after the walk.
// A new command is accepted in the cycle after the result is loaded.
// After reset the block writes the first and end headers in ST_INIT0 and
// ST_INIT1 with o_in_ready low; the rest of the header memory is not cleared.
// A stalled receiver holds the result in the output register; the next
// command is accepted and worked on, then waits for that register.
// Depends on hba_pkg, hba_hdr_mem and hba_engine.

module heap_block_allocator_core
    import hba_pkg::*;
#(
    parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [FIELD_W-1:0] i_request_size,
    input  logic [FIELD_W-1:0] i_user_address,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [FIELD_W-1:0] o_result_address,
    output logic               o_success,
    output logic [TOTAL_W-1:0] o_allocated_bytes,
    output logic [TOTAL_W-1:0] o_available_bytes
);

    localparam int HDR_WORDS = HEAP_BYTES / 4;
    localparam int AW        = $clog2(HDR_WORDS);

    logic             w_rd_en;
    logic [AW-1:0]    w_rd_addr;
    logic [HDR_W-1:0] w_rd_data;
    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    logic [HDR_W-1:0] w_wr_data;

    // command sequencer
    hba_engine #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_engine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_request_size    (i_request_size),
        .i_user_address    (i_user_address),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_result_address  (o_result_address),
        .o_success         (o_success),
        .o_allocated_bytes (o_allocated_bytes),
        .o_available_bytes (o_available_bytes),
        .o_mem_rd_en       (w_rd_en),
        .o_mem_rd_addr     (w_rd_addr),
        .i_mem_rd_data     (w_rd_data),
        .o_mem_wr_en       (w_wr_en),
        .o_mem_wr_addr     (w_wr_addr),
        .o_mem_wr_data     (w_wr_data)
    );

    // block headers, one word per four bytes of heap
    hba_hdr_mem #(
        .DEPTH (HDR_WORDS)
    ) u_hdr_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

endmodule

// File: design/hba_checker.sv
// port-level checks of the heap block allocator, bound to the top level
// depends on hba_pkg and heap_block_allocator_core

module hba_checker
    import hba_pkg::*;
#(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic [CMD_W-1:0]   i_cmd,
    input logic [FIELD_W-1:0] i_request_size,
    input logic [FIELD_W-1:0] i_user_address,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [FIELD_W-1:0] o_result_address,
    input logic               o_success,
    input logic [TOTAL_W-1:0] o_allocated_bytes,
    input logic [TOTAL_W-1:0] o_available_bytes
);

    localparam logic [TOTAL_W-1:0] HEAP_LO = TOTAL_W'(HEAP_BYTES);

    logic [TOTAL_W-1:0] w_sum;
    logic               w_unused;

    assign w_sum    = TOTAL_W'(o_allocated_bytes + o_available_bytes);
    assign w_unused = ^{i_cmd, i_request_size, i_user_address};

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // one command at a time: no acceptance right after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("command accepted while another is at work");

    // a failed command reports a zero address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_success |-> (o_result_address == '0))
        else $error("failed command with nonzero address");

    // allocated and available bytes add up to the heap while allocated is below it
    a_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n || w_unused === 1'bx)
        o_out_valid && (o_allocated_bytes < HEAP_BYTES) |-> (w_sum == HEAP_LO))
        else $error("allocated and available bytes do not balance");

endmodule

bind heap_block_allocator_core hba_checker #(.HEAP_BYTES(HEAP_BYTES)) u_hba_checker (.*);
